FILE: sv/sab_pkg.sv
package sab_pkg;

  localparam int MAX_LABELS = 256;
  localparam int LBL_W      = $clog2(MAX_LABELS);
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROWS_LIMIT = 4096;
  localparam int ROW_W      = $clog2(ROWS_LIMIT);

  localparam int FIELD_W = 16;
  localparam int OP_W    = 2;
  localparam int GEOM_W  = 13;

  // wide enough for clamped geometry and for position + 1
  localparam int DIM_A = (COL_W + 1 > GEOM_W) ? COL_W + 1 : GEOM_W;
  localparam int DIM_W = (ROW_W + 1 > DIM_A) ? ROW_W + 1 : DIM_A;

  // pairs marked per 2x2 window
  localparam int PAIRS = 4;
  localparam int CNT_W = $clog2(PAIRS);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [GEOM_W-1:0] FRAME_WIDTH_RST  = GEOM_W'(640);
  localparam logic [GEOM_W-1:0] FRAME_HEIGHT_RST = GEOM_W'(480);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] pixel_label;
    logic [FIELD_W-1:0] query_first;
    logic [FIELD_W-1:0] query_second;
  } in_item_t;

  typedef struct packed {
    logic adjacent;
    logic overflow_seen;
    logic clear_done;
  } out_item_t;

  typedef struct packed {
    logic             v;
    logic [LBL_W-1:0] lo;
    logic [LBL_W-1:0] hi;
  } pair_t;

  typedef struct packed {
    logic             en;
    logic [LBL_W-1:0] label;
  } mark_t;

  typedef struct packed {
    logic             clear;
    logic             op_en;
    logic             set;
    logic [LBL_W-1:0] lo;
    logic [LBL_W-1:0] hi;
  } adj_cmd_t;

endpackage

FILE: sv/sab_ram.sv
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/sab_line.sv
module sab_line import sab_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [GEOM_W-1:0]       frame_width,
  input  logic [GEOM_W-1:0]       frame_height,
  input  logic                    start,
  input  logic [FIELD_W-1:0]      label,
  input  logic                    clear,
  output mark_t                   mark,
  output pair_t [PAIRS-1:0]       pairs
);

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [LBL_W-1:0] tl_r, left_r, br_r;
  logic             tlv_r, leftv_r, brv_r, int_r, st_r;
  pair_t [PAIRS-1:0] pairs_r;

  logic [DIM_W-1:0] fw, fh, w_eff, h_eff, col_inc, row_inc;
  logic             last_col, last_row, ok;
  logic [LBL_W-1:0] lbl;
  logic [LBL_W:0]   tr_word;
  logic [LBL_W-1:0] tr;
  logic             trv;

  function automatic pair_t mk_pair(input logic en,
                                    input logic [LBL_W-1:0] a, input logic av,
                                    input logic [LBL_W-1:0] b, input logic bv);
    pair_t p;
    p.v  = en && av && bv && (a != b);
    p.lo = (a < b) ? a : b;
    p.hi = (a < b) ? b : a;
    return p;
  endfunction

  always_comb begin
    fw = DIM_W'(frame_width);
    fh = DIM_W'(frame_height);
    w_eff = (fw < DIM_W'(2)) ? DIM_W'(2) :
            (fw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw;
    h_eff = (fh < DIM_W'(2)) ? DIM_W'(2) :
            (fh > DIM_W'(ROWS_LIMIT)) ? DIM_W'(ROWS_LIMIT) : fh;
    col_inc  = DIM_W'(col_r) + DIM_W'(1);
    row_inc  = DIM_W'(row_r) + DIM_W'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
    ok  = ({1'b0, label} < (FIELD_W+1)'(MAX_LABELS));
    lbl = label[LBL_W-1:0];
    tr  = tr_word[LBL_W-1:0];
    trv = tr_word[LBL_W];
  end

  // previous row: written with the arriving label at the same column it is read from
  sab_ram #(
    .WIDTH(LBL_W + 1),
    .DEPTH(MAX_WIDTH)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (start),
    .wr_addr (col_r),
    .wr_data ({ok, lbl}),
    .rd_addr (col_r),
    .rd_data (tr_word)
  );

  assign mark.en    = start && ok &&
                      ((row_r == '0) || last_row || (col_r == '0) || last_col);
  assign mark.label = lbl;
  assign pairs      = pairs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      tl_r    <= '0;
      tlv_r   <= 1'b1;
      left_r  <= '0;
      leftv_r <= 1'b1;
      st_r    <= 1'b0;
    end else begin
      st_r <= start;
      if (clear) begin
        col_r <= '0;
        row_r <= '0;
      end else if (start) begin
        br_r  <= lbl;
        brv_r <= ok;
        int_r <= (row_r != '0) && (col_r != '0);
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col_r <= col_inc[COL_W-1:0];
        end
      end
      // top-right word is back: form the window pairs, then slide the window
      if (st_r) begin
        pairs_r[0] <= mk_pair(int_r, tl_r, tlv_r, left_r, leftv_r);
        pairs_r[1] <= mk_pair(int_r, tl_r, tlv_r, tr, trv);
        pairs_r[2] <= mk_pair(int_r, tl_r, tlv_r, br_r, brv_r);
        pairs_r[3] <= mk_pair(int_r, left_r, leftv_r, tr, trv);
        tl_r    <= tr;
        tlv_r   <= trv;
        left_r  <= br_r;
        leftv_r <= brv_r;
      end
    end
  end

endmodule

FILE: sv/sab_adj.sv
module sab_adj import sab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  adj_cmd_t cmd,
  input  mark_t    mark,
  output logic     q_bit
);

  logic [MAX_LABELS-1:0] rv_r, bnd_r;
  logic                  s1_v_r, s1_set_r, fwd_v_r;
  logic [LBL_W-1:0]      s1_lo_r, s1_hi_r, fwd_row_r;
  logic [MAX_LABELS-1:0] fwd_data_r;

  logic [MAX_LABELS-1:0] rd_data, row_cur, row_set;
  logic                  wr_en;

  // one row per lower label; a row without its valid bit reads as zero
  sab_ram #(
    .WIDTH(MAX_LABELS),
    .DEPTH(MAX_LABELS)
  ) u_matrix (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_lo_r),
    .wr_data (row_set),
    .rd_addr (cmd.lo),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en = s1_v_r && s1_set_r;
    // forward the row written in the cycle this read was issued
    if (fwd_v_r && (fwd_row_r == s1_lo_r)) begin
      row_cur = fwd_data_r;
    end else if (rv_r[s1_lo_r]) begin
      row_cur = rd_data;
    end else begin
      row_cur = '0;
    end
    row_set = row_cur | (MAX_LABELS'(1) << s1_hi_r);
    q_bit   = row_cur[s1_hi_r] | (bnd_r[s1_lo_r] & bnd_r[s1_hi_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r    <= '0;
      bnd_r   <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r     <= cmd.op_en;
      s1_set_r   <= cmd.set;
      s1_lo_r    <= cmd.lo;
      s1_hi_r    <= cmd.hi;
      fwd_v_r    <= wr_en && !cmd.clear;
      fwd_row_r  <= s1_lo_r;
      fwd_data_r <= row_set;
      if (cmd.clear) begin
        rv_r  <= '0;
        bnd_r <= '0;
      end else begin
        if (wr_en) begin
          rv_r[s1_lo_r] <= 1'b1;
        end
        if (mark.en) begin
          bnd_r[mark.label] <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/superpixel_adjacency_builder.sv
// Region adjacency builder for a superpixel label image. Pixel labels (op 1)
// arrive in raster order and produce no result; a query (op 2) returns whether
// two labels touch or both lie on the frame edge; a clear (op 0) wipes the
// matrix, the edge marks and the frame position and returns clear_done. The
// matrix holds one 256-bit row per lower label in a single-port-write RAM with
// per-row valid flops, so a clear is immediate and needs no sweep. A pixel
// reads the previous-row buffer, then forms the window pairs, then takes four
// read-modify-write slots on the matrix, one per window pair. A query reads
// the matrix (skipped when the labels alone decide it) before ST_RESP, which
// also ends a clear and waits for the output register to drain. Labels 256
// and up are dropped and set the sticky overflow flag. The user must write
// frame_width and frame_height only while the block is idle (not enforced).
module superpixel_adjacency_builder import sab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GEOM_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LINE  = 5'b00010,
    ST_MARK  = 5'b00100,
    ST_QWAIT = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [GEOM_W-1:0] fw_r, fh_r;
  logic             ovf_r, out_valid_r, resp_adj_r, resp_clr_r;
  out_item_t        out_item_r;

  logic             accept, pix_ok, q_ok, q_same, line_start, line_clear, q_bit;
  logic [LBL_W-1:0] qa, qb;
  adj_cmd_t         adj_cmd;
  mark_t            mark;
  pair_t [PAIRS-1:0] pairs;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    pix_ok = ({1'b0, in_item.pixel_label} < (FIELD_W+1)'(MAX_LABELS));
    q_ok   = ({1'b0, in_item.query_first}  < (FIELD_W+1)'(MAX_LABELS)) &&
             ({1'b0, in_item.query_second} < (FIELD_W+1)'(MAX_LABELS));
    q_same = (in_item.query_first == in_item.query_second);
    qa     = in_item.query_first[LBL_W-1:0];
    qb     = in_item.query_second[LBL_W-1:0];
  end

  always_comb begin
    adj_cmd    = '0;
    line_start = 1'b0;
    line_clear = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.op)
            OP_CLEAR: begin
              adj_cmd.clear = 1'b1;
              line_clear    = 1'b1;
              state_nxt     = ST_RESP;
            end
            OP_PIXEL: begin
              line_start = 1'b1;
              state_nxt  = ST_LINE;
            end
            OP_QUERY: begin
              if (q_ok && !q_same) begin
                adj_cmd.op_en = 1'b1;
                adj_cmd.lo    = (qa < qb) ? qa : qb;
                adj_cmd.hi    = (qa < qb) ? qb : qa;
                state_nxt     = ST_QWAIT;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LINE: state_nxt = ST_MARK;
      ST_MARK: begin
        adj_cmd.op_en = pairs[cnt_r].v;
        adj_cmd.set   = 1'b1;
        adj_cmd.lo    = pairs[cnt_r].lo;
        adj_cmd.hi    = pairs[cnt_r].hi;
        if (cnt_r == CNT_W'(PAIRS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QWAIT: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  sab_line u_line (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .start        (line_start),
    .label        (in_item.pixel_label),
    .clear        (line_clear),
    .mark         (mark),
    .pairs        (pairs)
  );

  sab_adj u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (adj_cmd),
    .mark  (mark),
    .q_bit (q_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      fw_r        <= FRAME_WIDTH_RST;
      fh_r        <= FRAME_HEIGHT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        endcase
      end
      if ((state_r == ST_RESP) && (!out_valid_r || !out_stall)) begin
        // load the result once the output register is free or being drained
        out_valid_r              <= 1'b1;
        out_item_r.adjacent      <= resp_adj_r;
        out_item_r.overflow_seen <= ovf_r;
        out_item_r.clear_done    <= resp_clr_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            resp_adj_r <= 1'b0;
            resp_clr_r <= (in_item.op == OP_CLEAR);
            if ((in_item.op == OP_PIXEL && !pix_ok) ||
                (in_item.op == OP_QUERY && !q_ok)) begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_LINE:  cnt_r <= '0;
        ST_MARK:  cnt_r <= cnt_r + CNT_W'(1);
        ST_QWAIT: resp_adj_r <= q_bit;
        default: ;
      endcase
    end
  end

endmodule
